### src/c2s_pkg.sv
`default_nettype none

package c2s_pkg;

    // Fixed field widths
    localparam int ROW_W = 6;
    localparam int COL_W = 10;

    // Row store geometry
    localparam int ROWS   = 64;
    localparam int ROW_AW = $clog2(ROWS);

    // Canonical empty extent
    localparam logic [ROW_W-1:0] EMPTY_TOP = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] EMPTY_BOT = '0;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] top;
        logic [ROW_W-1:0] bottom;
        logic             first;
    } t_c2s_in;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] span_start;
        logic [COL_W-1:0] span_end;
        logic             last;
    } t_c2s_out;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_EMIT,
        S_OPEN
    } t_c2s_state;

    // Span load request from the sequencer to the output stage
    typedef struct packed {
        logic             load;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] span_end;
        logic             last;
    } t_c2s_emit;

    // One step of a row walk: row touched and the updated bounds
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] top;
        logic [ROW_W-1:0] bot;
    } t_c2s_step;

endpackage

`default_nettype wire

### src/column_to_span_converter.sv
`default_nettype none

// Column to span converter.
// Input channel (i_valid / o_ready / i_data) takes one column word: column
// index, top and bottom covered rows, and a first flag that opens a new plane.
// Output channel (o_valid / i_ready / o_data) gives one word per closed row:
// row, start column, end column (column minus one) and a last flag on the
// final span of that column. A column that closes nothing gives no word.
// Feed an empty column (top above bottom) to flush the open rows.
// Per column the sequencer walks the rows it touches one per cycle, unless the
// output stalls, through a 64-entry start-column store that is never read and
// written in the same cycle and has a registered read: closed rows are read and
// emitted, newly covered rows are written. The first span is read in S_CLOSE and
// loaded from S_EMIT; the rest follow one per cycle while the receiver keeps up.
// o_ready is high only between columns. A stalled receiver holds the output
// register and the sequencer waits on it without losing a span.
// Reset empties the previous extent and the output register; the start store
// is not cleared, since a row is always opened before it is closed.
module column_to_span_converter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire c2s_pkg::t_c2s_in  i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output c2s_pkg::t_c2s_out      o_data
);
    import c2s_pkg::*;

    t_c2s_emit         emit;
    logic              out_free;
    logic              rd_en, wr_en;
    logic [ROW_AW-1:0] rd_addr, wr_addr;
    logic [COL_W-1:0]  rd_data, wr_data;

    c2s_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    c2s_row_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    c2s_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (emit),
        .i_span_start (rd_data),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

    // A span is never loaded over a word that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.load |-> (!o_valid || i_ready))
        else $error("span loaded over a pending word");

    // The store is never read and written in the same cycle
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("store read and write collide");

    // No store access while waiting for a column
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!rd_en && !wr_en && !emit.load))
        else $error("store access while idle");

    // Every load takes a start column that was just read or has stayed stable since
    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.load |-> ($past(rd_en) || $stable(rd_data)))
        else $error("span loaded without fetched start");

endmodule

`default_nettype wire

### src/c2s_row_store.sv
`default_nettype none

module c2s_row_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_rd_en,
    input  wire logic [c2s_pkg::ROW_AW-1:0] i_rd_addr,
    output logic      [c2s_pkg::COL_W-1:0]  o_rd_data,
    input  wire logic                      i_wr_en,
    input  wire logic [c2s_pkg::ROW_AW-1:0] i_wr_addr,
    input  wire logic [c2s_pkg::COL_W-1:0]  i_wr_data
);
    import c2s_pkg::*;

    logic [COL_W-1:0] r_mem [ROWS];
    logic [COL_W-1:0] r_rd_data;

    // Write the start column of an opened row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; hold the word between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/c2s_sequencer.sv
`default_nettype none

module c2s_sequencer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire c2s_pkg::t_c2s_in           i_data,
    input  wire logic                       i_out_free,
    output c2s_pkg::t_c2s_emit              o_emit,
    output logic                            o_rd_en,
    output logic      [c2s_pkg::ROW_AW-1:0] o_rd_addr,
    output logic                            o_wr_en,
    output logic      [c2s_pkg::ROW_AW-1:0] o_wr_addr,
    output logic      [c2s_pkg::COL_W-1:0]  o_wr_data
);
    import c2s_pkg::*;

    t_c2s_state       r_state, n_state;
    logic [ROW_W-1:0] r_t1, n_t1, r_b1, n_b1;
    logic [ROW_W-1:0] r_t2, n_t2, r_b2, n_b2;
    logic [ROW_W-1:0] r_prev_top, n_prev_top, r_prev_bot, n_prev_bot;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col, r_end, n_end;

    logic [ROW_W-1:0] bot_sat, new_top, new_bot;
    logic             col_empty;
    t_c2s_step        cs, os;

    // Next row to close: old top rows ascending, then old bottom rows descending
    function automatic t_c2s_step close_step(
        input logic [ROW_W-1:0] t1, input logic [ROW_W-1:0] b1,
        input logic [ROW_W-1:0] t2, input logic [ROW_W-1:0] b2);
        t_c2s_step s;
        s.valid = 1'b0;
        s.row   = t1;
        s.top   = t1;
        s.bot   = b1;
        if (t1 < t2 && t1 <= b1) begin
            s.valid = 1'b1;
            s.top   = t1 + ROW_W'(1);
        end else if (b1 > b2 && b1 >= t1) begin
            s.valid = 1'b1;
            s.row   = b1;
            s.bot   = b1 - ROW_W'(1);
        end
        return s;
    endfunction

    // Next row to open: new top rows ascending, then new bottom rows descending
    function automatic t_c2s_step open_step(
        input logic [ROW_W-1:0] t1, input logic [ROW_W-1:0] b1,
        input logic [ROW_W-1:0] t2, input logic [ROW_W-1:0] b2);
        t_c2s_step s;
        s.valid = 1'b0;
        s.row   = t2;
        s.top   = t2;
        s.bot   = b2;
        if (t2 < t1 && t2 <= b2) begin
            s.valid = 1'b1;
            s.top   = t2 + ROW_W'(1);
        end else if (b2 > b1 && b2 >= t2) begin
            s.valid = 1'b1;
            s.row   = b2;
            s.bot   = b2 - ROW_W'(1);
        end
        return s;
    endfunction

    // Clamp the incoming extent and fold any empty one to the canonical form
    always_comb begin
        bot_sat   = ({1'b0, i_data.bottom} > (ROW_W + 1)'(ROWS - 1)) ? EMPTY_TOP
                                                                     : i_data.bottom;
        col_empty = i_data.top > bot_sat;
        new_top   = col_empty ? EMPTY_TOP : i_data.top;
        new_bot   = col_empty ? EMPTY_BOT : bot_sat;
    end

    assign cs = close_step(r_t1, r_b1, r_t2, r_b2);
    assign os = open_step(r_t1, r_b1, r_t2, r_b2);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CLOSE;
            S_CLOSE: n_state = cs.valid ? S_EMIT : S_OPEN;
            S_EMIT:  if (i_out_free && !cs.valid) n_state = S_OPEN;
            S_OPEN:  if (!os.valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and loop bounds
    always_comb begin
        n_t1       = r_t1;
        n_b1       = r_b1;
        n_t2       = r_t2;
        n_b2       = r_b2;
        n_prev_top = r_prev_top;
        n_prev_bot = r_prev_bot;
        n_row      = r_row;
        n_col      = r_col;
        n_end      = r_end;
        o_ready    = 1'b0;
        o_emit     = '0;
        o_rd_en    = 1'b0;
        o_rd_addr  = cs.row[ROW_AW-1:0];
        o_wr_en    = 1'b0;
        o_wr_addr  = os.row[ROW_AW-1:0];
        o_wr_data  = r_col;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_t1       = i_data.first ? EMPTY_TOP : r_prev_top;
                    n_b1       = i_data.first ? EMPTY_BOT : r_prev_bot;
                    n_t2       = new_top;
                    n_b2       = new_bot;
                    n_prev_top = new_top;
                    n_prev_bot = new_bot;
                    n_col      = i_data.column;
                    n_end      = i_data.column - COL_W'(1);
                end
            end
            S_CLOSE: begin
                if (cs.valid) begin
                    o_rd_en = 1'b1;
                    n_t1    = cs.top;
                    n_b1    = cs.bot;
                    n_row   = cs.row;
                end
            end
            S_EMIT: begin
                // Hand over the fetched span and fetch the next one behind it
                if (i_out_free) begin
                    o_emit.load     = 1'b1;
                    o_emit.row      = r_row;
                    o_emit.span_end = r_end;
                    o_emit.last     = !cs.valid;
                    if (cs.valid) begin
                        o_rd_en = 1'b1;
                        n_t1    = cs.top;
                        n_b1    = cs.bot;
                        n_row   = cs.row;
                    end
                end
            end
            S_OPEN: begin
                if (os.valid) begin
                    o_wr_en = 1'b1;
                    n_t2    = os.top;
                    n_b2    = os.bot;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_top <= EMPTY_TOP;
            r_prev_bot <= EMPTY_BOT;
        end else begin
            r_state    <= n_state;
            r_prev_top <= n_prev_top;
            r_prev_bot <= n_prev_bot;
        end
    end

    // Working registers of the current column
    always_ff @(posedge i_clk) begin
        r_t1  <= n_t1;
        r_b1  <= n_b1;
        r_t2  <= n_t2;
        r_b2  <= n_b2;
        r_row <= n_row;
        r_col <= n_col;
        r_end <= n_end;
    end

endmodule

`default_nettype wire

### src/c2s_out_stage.sv
`default_nettype none

module c2s_out_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire c2s_pkg::t_c2s_emit        i_emit,
    input  wire logic [c2s_pkg::COL_W-1:0] i_span_start,
    output logic                           o_free,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output c2s_pkg::t_c2s_out              o_data
);
    import c2s_pkg::*;

    logic     r_valid;
    t_c2s_out r_data;

    assign o_free = !r_valid || i_ready;

    // Hold the word until taken; refill as it leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_data.row        <= i_emit.row;
            r_data.span_start <= i_span_start;
            r_data.span_end   <= i_emit.span_end;
            r_data.last       <= i_emit.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire
